### rtl/core/fhex_pkg.sv
package fhex_pkg;

    localparam int TEXT_MAX  = 16;
    localparam int FRAC_NIBS = 6;
    localparam int DEC_DIGS  = 3;

    localparam logic [7:0] EXP_SPECIAL = 8'hff;
    localparam logic [8:0] SUB_BIAS    = 9'd149;
    localparam logic [8:0] NORM_BIAS   = 9'd127;

    typedef logic [6:0] char_t;

    typedef enum logic [1:0] {
        CLS_NUM  = 2'd0,
        CLS_ZERO = 2'd1,
        CLS_INF  = 2'd2,
        CLS_NAN  = 2'd3
    } val_class_t;

    localparam char_t CH_MINUS = 7'h2d;
    localparam char_t CH_PLUS  = 7'h2b;
    localparam char_t CH_DOT   = 7'h2e;
    localparam char_t CH_ZERO  = 7'h30;
    localparam char_t CH_ONE   = 7'h31;
    localparam char_t CH_A     = 7'h61;
    localparam char_t CH_F     = 7'h66;
    localparam char_t CH_I     = 7'h69;
    localparam char_t CH_N     = 7'h6e;
    localparam char_t CH_P     = 7'h70;
    localparam char_t CH_X     = 7'h78;

    function automatic char_t hex_char(input logic [3:0] nib);
        char_t c;
        if (nib < 4'd10)
        begin
            c = CH_ZERO + char_t'(nib);
        end
        else
        begin
            c = CH_A + char_t'(nib - 4'd10);
        end
        return c;
    endfunction

    function automatic char_t dec_char(input logic [3:0] dig);
        return CH_ZERO + char_t'(dig);
    endfunction

endpackage

### rtl/core/float_to_hex_text_unit.sv
// Formats an IEEE single bit pattern as hexadecimal float text ("-0x1.8p+3", "inf", "-nan",
// "0x0p+0"), one ASCII character per output beat with is_last on the final character.
// A value passes three register stages (decode, normalize/exponent, digit extraction)
// before its text is assembled into the character register that drives the output.
// Each value's text is 3 to 16 characters long, and the single character port sets the
// sustained rate: one character per cycle while text_ready is high, with no gap between
// values while the stages hold work.
// The input side keeps taking beats back to back until the stages fill up.
module float_to_hex_text_unit
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  float_valid,
    output logic                  float_ready,
    input  logic [31:0]           float_bits,
    output logic                  text_valid,
    input  logic                  text_ready,
    output fhex_pkg::char_t       text_char,
    output logic                  is_last
);
    import fhex_pkg::*;

    // stage 1: decode
    logic        s1_v_reg;
    logic        s1_sign_reg;
    val_class_t  s1_cls_reg;
    logic [7:0]  s1_expo_reg;
    logic [22:0] s1_mant_reg;
    logic [4:0]  s1_lead_reg;

    // stage 2: fraction and exponent magnitude
    logic        s2_v_reg;
    logic        s2_sign_reg;
    val_class_t  s2_cls_reg;
    logic [23:0] s2_frac_reg;
    logic        s2_neg_reg;
    logic [7:0]  s2_mag_reg;

    // stage 3: digits
    logic        s3_v_reg;
    logic        s3_sign_reg;
    val_class_t  s3_cls_reg;
    logic [23:0] s3_frac_reg;
    logic [2:0]  s3_ndig_reg;
    logic        s3_neg_reg;
    logic [1:0]  s3_ndec_reg;
    logic [3:0]  s3_dec_reg [DEC_DIGS];

    // character register
    logic        ser_v_reg;
    char_t       ser_buf_reg [TEXT_MAX];
    logic [3:0]  ser_idx_reg;
    logic [3:0]  ser_last_reg;

    logic        ser_take;
    logic        s3_ready;
    logic        s2_ready;

    assign ser_take    = !ser_v_reg || (text_ready && (ser_idx_reg == ser_last_reg));
    assign s3_ready    = !s3_v_reg || ser_take;
    assign s2_ready    = !s2_v_reg || s3_ready;
    assign float_ready = !s1_v_reg || s2_ready;

    assign text_valid = ser_v_reg;
    assign text_char  = ser_buf_reg[ser_idx_reg];
    assign is_last    = (ser_idx_reg == ser_last_reg);

    // ---------------- stage 1 ----------------
    logic [7:0]  in_expo;
    logic [22:0] in_mant;
    val_class_t  s1_cls_next;
    logic [4:0]  s1_lead_next;

    assign in_expo = float_bits[30:23];
    assign in_mant = float_bits[22:0];

    always_comb
    begin
        if (in_expo == EXP_SPECIAL)
        begin
            s1_cls_next = (in_mant == 23'd0) ? CLS_INF : CLS_NAN;
        end
        else if (in_expo == 8'd0 && in_mant == 23'd0)
        begin
            s1_cls_next = CLS_ZERO;
        end
        else
        begin
            s1_cls_next = CLS_NUM;
        end
        s1_lead_next = 5'd0;
        for (int b = 0; b < 23; b++)
        begin
            if (in_mant[b])
            begin
                s1_lead_next = 5'(b);
            end
        end
    end

    // ---------------- stage 2 ----------------
    logic [22:0] mant_clr;
    logic [4:0]  shamt;
    logic [46:0] sub_shift;
    logic [23:0] s2_frac_next;
    logic [8:0]  power;
    logic        s2_neg_next;
    logic [7:0]  s2_mag_next;

    always_comb
    begin
        mant_clr  = s1_mant_reg & ~(23'd1 << s1_lead_reg);
        shamt     = 5'd24 - s1_lead_reg;
        sub_shift = {24'd0, mant_clr} << shamt;
        if (s1_expo_reg == 8'd0)
        begin
            s2_frac_next = sub_shift[23:0];
            power        = {4'd0, s1_lead_reg} - SUB_BIAS;
        end
        else
        begin
            s2_frac_next = {s1_mant_reg, 1'b0};
            power        = {1'b0, s1_expo_reg} - NORM_BIAS;
        end
        s2_neg_next = power[8];
        s2_mag_next = s2_neg_next ? 8'(9'd0 - power) : power[7:0];
    end

    // ---------------- stage 3 ----------------
    logic        hund;
    logic [6:0]  rem;
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic [3:0]  ones;
    logic [2:0]  s3_ndig_next;
    logic [1:0]  s3_ndec_next;
    logic [3:0]  s3_dec_next [DEC_DIGS];

    always_comb
    begin
        hund      = (s2_mag_reg >= 8'd100);
        rem       = hund ? 7'(s2_mag_reg - 8'd100) : s2_mag_reg[6:0];
        // divide by ten via reciprocal, exact below 100
        tens_prod = 15'(rem) * 15'd205;
        tens      = tens_prod[14:11];
        ones      = 4'(rem - 7'(tens) * 7'd10);
        s3_dec_next[0] = 4'd0;
        s3_dec_next[1] = 4'd0;
        s3_dec_next[2] = 4'd0;
        if (hund)
        begin
            s3_ndec_next   = 2'd3;
            s3_dec_next[0] = 4'd1;
            s3_dec_next[1] = tens;
            s3_dec_next[2] = ones;
        end
        else if (tens != 4'd0)
        begin
            s3_ndec_next   = 2'd2;
            s3_dec_next[0] = tens;
            s3_dec_next[1] = ones;
        end
        else
        begin
            s3_ndec_next   = 2'd1;
            s3_dec_next[0] = ones;
        end
        // drop trailing zero nibbles
        if (s2_frac_reg[3:0] != 4'd0)
        begin
            s3_ndig_next = 3'd6;
        end
        else if (s2_frac_reg[7:4] != 4'd0)
        begin
            s3_ndig_next = 3'd5;
        end
        else if (s2_frac_reg[11:8] != 4'd0)
        begin
            s3_ndig_next = 3'd4;
        end
        else if (s2_frac_reg[15:12] != 4'd0)
        begin
            s3_ndig_next = 3'd3;
        end
        else if (s2_frac_reg[19:16] != 4'd0)
        begin
            s3_ndig_next = 3'd2;
        end
        else if (s2_frac_reg[23:20] != 4'd0)
        begin
            s3_ndig_next = 3'd1;
        end
        else
        begin
            s3_ndig_next = 3'd0;
        end
    end

    // ---------------- text assembly ----------------
    logic [3:0] nibs [FRAC_NIBS];
    logic [3:0] q_pos;
    logic [3:0] num_last;
    char_t      ser_buf_next [TEXT_MAX];
    logic [3:0] ser_last_next;

    always_comb
    begin
        for (int i = 0; i < FRAC_NIBS; i++)
        begin
            nibs[i] = s3_frac_reg[23 - 4 * i -: 4];
        end
        // position of 'p' relative to the first non-sign character
        q_pos    = (s3_ndig_reg != 3'd0) ? 4'd4 + 4'(s3_ndig_reg) : 4'd3;
        num_last = q_pos + 4'd1 + 4'(s3_ndec_reg);
        case (s3_cls_reg)
            CLS_NUM:  ser_last_next = num_last + 4'(s3_sign_reg);
            CLS_ZERO: ser_last_next = 4'd5 + 4'(s3_sign_reg);
            CLS_INF:  ser_last_next = 4'd2 + 4'(s3_sign_reg);
            CLS_NAN:  ser_last_next = 4'd2 + 4'(s3_sign_reg);
            default:  ser_last_next = 4'd2;
        endcase
    end

    always_comb
    begin
        logic [3:0] j;
        logic [2:0] n;
        logic [3:0] dp;
        for (int k = 0; k < TEXT_MAX; k++)
        begin
            j  = 4'(k) - 4'(s3_sign_reg);
            n  = 3'(j - 4'd4);
            dp = j - q_pos - 4'd2;
            ser_buf_next[k] = CH_ZERO;
            if (s3_sign_reg && k == 0)
            begin
                ser_buf_next[k] = CH_MINUS;
            end
            else
            begin
                case (s3_cls_reg)
                    CLS_INF:
                    begin
                        if (j == 4'd0)
                        begin
                            ser_buf_next[k] = CH_I;
                        end
                        else if (j == 4'd1)
                        begin
                            ser_buf_next[k] = CH_N;
                        end
                        else
                        begin
                            ser_buf_next[k] = CH_F;
                        end
                    end
                    CLS_NAN:
                    begin
                        ser_buf_next[k] = (j == 4'd1) ? CH_A : CH_N;
                    end
                    CLS_ZERO:
                    begin
                        if (j == 4'd1)
                        begin
                            ser_buf_next[k] = CH_X;
                        end
                        else if (j == 4'd3)
                        begin
                            ser_buf_next[k] = CH_P;
                        end
                        else if (j == 4'd4)
                        begin
                            ser_buf_next[k] = CH_PLUS;
                        end
                        else
                        begin
                            ser_buf_next[k] = CH_ZERO;
                        end
                    end
                    CLS_NUM:
                    begin
                        if (j == 4'd0)
                        begin
                            ser_buf_next[k] = CH_ZERO;
                        end
                        else if (j == 4'd1)
                        begin
                            ser_buf_next[k] = CH_X;
                        end
                        else if (j == 4'd2)
                        begin
                            ser_buf_next[k] = CH_ONE;
                        end
                        else if (j < q_pos && j == 4'd3)
                        begin
                            ser_buf_next[k] = CH_DOT;
                        end
                        else if (j < q_pos && n < 3'(FRAC_NIBS))
                        begin
                            ser_buf_next[k] = hex_char(nibs[n]);
                        end
                        else if (j == q_pos)
                        begin
                            ser_buf_next[k] = CH_P;
                        end
                        else if (j == q_pos + 4'd1)
                        begin
                            ser_buf_next[k] = s3_neg_reg ? CH_MINUS : CH_PLUS;
                        end
                        else if (j >= q_pos + 4'd2 && dp < 4'(DEC_DIGS))
                        begin
                            ser_buf_next[k] = dec_char(s3_dec_reg[dp[1:0]]);
                        end
                        else
                        begin
                            ser_buf_next[k] = CH_ZERO;
                        end
                    end
                    default:
                    begin
                        ser_buf_next[k] = CH_ZERO;
                    end
                endcase
            end
        end
    end

    // ---------------- valid bits ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg    <= 1'b0;
            s2_v_reg    <= 1'b0;
            s3_v_reg    <= 1'b0;
            ser_v_reg   <= 1'b0;
            ser_idx_reg <= 4'd0;
        end
        else
        begin
            if (float_ready)
            begin
                s1_v_reg <= float_valid;
            end
            if (s2_ready)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (s3_ready)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (ser_take)
            begin
                ser_v_reg   <= s3_v_reg;
                ser_idx_reg <= 4'd0;
            end
            else if (text_ready)
            begin
                // advance to the next character of this value
                ser_idx_reg <= ser_idx_reg + 4'd1;
            end
        end
    end

    // ---------------- payload ----------------
    always_ff @(posedge clk)
    begin
        if (float_ready && float_valid)
        begin
            s1_sign_reg <= float_bits[31];
            s1_cls_reg  <= s1_cls_next;
            s1_expo_reg <= in_expo;
            s1_mant_reg <= in_mant;
            s1_lead_reg <= s1_lead_next;
        end
        if (s2_ready && s1_v_reg)
        begin
            s2_sign_reg <= s1_sign_reg;
            s2_cls_reg  <= s1_cls_reg;
            s2_frac_reg <= s2_frac_next;
            s2_neg_reg  <= s2_neg_next;
            s2_mag_reg  <= s2_mag_next;
        end
        if (s3_ready && s2_v_reg)
        begin
            s3_sign_reg <= s2_sign_reg;
            s3_cls_reg  <= s2_cls_reg;
            s3_frac_reg <= s2_frac_reg;
            s3_ndig_reg <= s3_ndig_next;
            s3_neg_reg  <= s2_neg_reg;
            s3_ndec_reg <= s3_ndec_next;
            s3_dec_reg  <= s3_dec_next;
        end
        if (ser_take && s3_v_reg)
        begin
            ser_buf_reg  <= ser_buf_next;
            ser_last_reg <= ser_last_next;
        end
    end

    // ---------------- checks ----------------
    a_idx_in_text: assert property (@(posedge clk) disable iff (!rst_n)
        ser_v_reg |-> ser_idx_reg <= ser_last_reg)
        else $error("character index past end of text");

    a_min_length: assert property (@(posedge clk) disable iff (!rst_n)
        ser_v_reg |-> ser_last_reg >= 4'd2)
        else $error("text shorter than three characters");

    a_s3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s3_v_reg && !ser_take |=> s3_v_reg && $stable(s3_frac_reg) && $stable(s3_cls_reg))
        else $error("stage 3 lost or changed a stalled value");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        float_valid && float_ready |=> s1_v_reg)
        else $error("accepted beat not captured in stage 1");

endmodule
